[sv/mhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared types and constants for the min-heap sorter.
// ----------------------------------------------------------------------------
package mhs_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

[sv/mhs_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mhs_store
// Heap storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhs_store
	import mhs_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire data_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output data_t              rdata_q
);

	data_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[sv/min_heap_sorter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_sorter
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Values are loaded one per cycle into a store of MAX_ITEMS entries; values
// past capacity are dropped and every result of that set carries overflowed.
// The item with is_last closes the set: the block builds a min-heap in place
// and then emits the root repeatedly, end_of_run marking the largest value.
// in_ready is low from the closing item until the last result is loaded into
// the output register. All work goes through one store read port and one
// signed comparator. A sift-down level steps through ST_SIFT_LC, ST_SIFT_RC
// when a right child exists, ST_SIFT_CMP and ST_SIFT_DESC; each result adds
// ST_SIFT_START, ST_EMIT_TAKE and ST_SIFT_VAL. The heap build and any output
// stall come on top of the emission steps.
module min_heap_sorter
	import mhs_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire data_t value,
	input  wire logic is_last,
	output logic      out_valid,
	input  wire logic out_ready,
	output data_t     sorted_value,
	output logic      end_of_run,
	output logic      overflowed
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int LW = AW + 2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SIFT_START,
		ST_SIFT_VAL,
		ST_SIFT_LC,
		ST_SIFT_RC,
		ST_SIFT_CMP,
		ST_SIFT_DESC,
		ST_EMIT_TAKE
	} state_t;

	state_t          state_q;
	logic            emit_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   bi_q;
	logic            ovf_q;
	logic [AW-1:0]   node_q;
	logic [AW-1:0]   pick_q;
	data_t           val_q;
	data_t           lcv_q;
	data_t           pv_q;
	logic            out_valid_q;
	data_t           out_val_q;
	logic            out_end_q;
	logic            out_ovf_q;

	logic            we;
	logic [AW-1:0]   waddr;
	data_t           wdata;
	logic [AW-1:0]   raddr;
	data_t           rdata;

	logic [LW-1:0]   lc;
	logic [LW-1:0]   rc;
	logic [LW-1:0]   size_ext;
	logic            lc_out;
	logic            rc_in;
	data_t           cmp_a;
	data_t           cmp_b;
	logic            lt;
	logic            in_acc;
	logic            has_room;
	logic [CW-1:0]   cnt_nx;
	logic [CW-1:0]   half_nx;
	logic            slot_free;

	mhs_store #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata_q(rdata)
	);

	assign lc       = {1'b0, node_q, 1'b1};
	assign rc       = lc + LW'(1);
	assign size_ext = LW'(count_q);
	assign lc_out   = lc >= size_ext;
	assign rc_in    = rc < size_ext;

	// shared comparator
	assign cmp_a = (state_q == ST_SIFT_RC) ? lcv_q : pv_q;
	assign cmp_b = (state_q == ST_SIFT_RC) ? rdata : val_q;
	assign lt    = cmp_a < cmp_b;

	assign in_ready  = (state_q == ST_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign has_room  = count_q < CW'(MAX_ITEMS);
	assign cnt_nx    = has_room ? count_q + CW'(1) : count_q;
	assign half_nx   = cnt_nx >> 1;
	assign slot_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign sorted_value = out_val_q;
	assign end_of_run   = out_end_q;
	assign overflowed   = out_ovf_q;

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = val_q;
		raddr = node_q;
		case (state_q)
			ST_LOAD: begin
				we    = in_acc && has_room;
				waddr = count_q[AW-1:0];
				wdata = value;
			end
			ST_SIFT_START: begin
				raddr = node_q;
			end
			ST_SIFT_VAL: begin
				if (lc_out) begin
					we    = 1'b1;
					wdata = rdata;
				end else begin
					raddr = lc[AW-1:0];
				end
			end
			ST_SIFT_LC: begin
				raddr = rc[AW-1:0];
			end
			ST_SIFT_CMP: begin
				we    = 1'b1;
				wdata = lt ? pv_q : val_q;
			end
			ST_SIFT_DESC: begin
				if (lc_out) begin
					we = 1'b1;
				end else begin
					raddr = lc[AW-1:0];
				end
			end
			ST_EMIT_TAKE: begin
				raddr = slot_free ? AW'(count_q - CW'(1)) : '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			emit_q      <= 1'b0;
			count_q     <= '0;
			bi_q        <= '0;
			ovf_q       <= 1'b0;
			node_q      <= '0;
			pick_q      <= '0;
			val_q       <= '0;
			lcv_q       <= '0;
			pv_q        <= '0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_end_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT_TAKE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= cnt_nx;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (is_last) begin
							if (half_nx == '0) begin
								emit_q  <= 1'b1;
								node_q  <= '0;
								state_q <= ST_SIFT_START;
							end else begin
								emit_q  <= 1'b0;
								node_q  <= AW'(half_nx - CW'(1));
								bi_q    <= half_nx - CW'(1);
								state_q <= ST_SIFT_START;
							end
						end
					end
				end
				ST_SIFT_START: begin
					state_q <= emit_q ? ST_EMIT_TAKE : ST_SIFT_VAL;
				end
				ST_SIFT_VAL: begin
					val_q <= rdata;
					if (lc_out) begin
						if (emit_q || bi_q == '0) begin
							emit_q  <= 1'b1;
							node_q  <= '0;
							state_q <= ST_SIFT_START;
						end else begin
							node_q  <= AW'(bi_q - CW'(1));
							bi_q    <= bi_q - CW'(1);
							state_q <= ST_SIFT_START;
						end
					end else begin
						state_q <= ST_SIFT_LC;
					end
				end
				ST_SIFT_LC: begin
					lcv_q  <= rdata;
					pick_q <= lc[AW-1:0];
					pv_q   <= rdata;
					state_q <= rc_in ? ST_SIFT_RC : ST_SIFT_CMP;
				end
				ST_SIFT_RC: begin
					if (!lt) begin
						pick_q <= rc[AW-1:0];
						pv_q   <= rdata;
					end
					state_q <= ST_SIFT_CMP;
				end
				ST_SIFT_CMP: begin
					if (lt) begin
						node_q  <= pick_q;
						state_q <= ST_SIFT_DESC;
					end else if (emit_q || bi_q == '0) begin
						emit_q  <= 1'b1;
						node_q  <= '0;
						state_q <= ST_SIFT_START;
					end else begin
						node_q  <= AW'(bi_q - CW'(1));
						bi_q    <= bi_q - CW'(1);
						state_q <= ST_SIFT_START;
					end
				end
				ST_SIFT_DESC: begin
					if (lc_out) begin
						if (emit_q || bi_q == '0) begin
							emit_q  <= 1'b1;
							node_q  <= '0;
							state_q <= ST_SIFT_START;
						end else begin
							node_q  <= AW'(bi_q - CW'(1));
							bi_q    <= bi_q - CW'(1);
							state_q <= ST_SIFT_START;
						end
					end else begin
						state_q <= ST_SIFT_LC;
					end
				end
				ST_EMIT_TAKE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_val_q   <= rdata;
						out_end_q   <= (count_q == CW'(1));
						out_ovf_q   <= ovf_q;
						count_q     <= count_q - CW'(1);
						node_q      <= '0;
						if (count_q == CW'(1)) begin
							ovf_q   <= 1'b0;
							emit_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_SIFT_VAL;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[verif/min_heap_sorter_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_sorter_chk
// Scoreboard for the min-heap sorter.
// ----------------------------------------------------------------------------
// Watches both channels. Accepted values are kept in ascending order as they
// arrive, up to the store capacity. Later values only raise the dropped flag.
// A closing item turns the held set into the expected result stream: the
// largest value is marked end_of_run, and every result carries the flag.
// Each accepted result is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module min_heap_sorter_chk
	import mhs_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire data_t value,
	input  wire logic is_last,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire data_t sorted_value,
	input  wire logic end_of_run,
	input  wire logic overflowed,
	output int        fails,
	output int        pending
);

	typedef struct packed {
		data_t v;
		logic  eor;
		logic  ovf;
	} sorted_item_t;

	sorted_item_t expected_sorted[$];
	data_t        held [CAPACITY];
	int           held_n;
	logic         dropped;

	always @(posedge clk or negedge arst_n) begin
		sorted_item_t want;
		int j;
		if (!arst_n) begin
			held_n = 0;
			dropped = 1'b0;
			expected_sorted.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sorted.size() == 0) begin
					$error("sorted_value %0d arrived with nothing expected", sorted_value);
					fails++;
				end else begin
					want = expected_sorted.pop_front();
					if (sorted_value !== want.v) begin
						$error("sorted_value: expected %0d, got %0d", want.v, sorted_value);
						fails++;
					end
					if (end_of_run !== want.eor) begin
						$error("end_of_run: expected %0b, got %0b", want.eor, end_of_run);
						fails++;
					end
					if (overflowed !== want.ovf) begin
						$error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (held_n < CAPACITY) begin
					j = held_n;
					while (j > 0 && held[j-1] > value) begin
						held[j] = held[j-1];
						j--;
					end
					held[j] = value;
					held_n++;
				end else begin
					dropped = 1'b1;
				end
				if (is_last) begin
					for (j = 0; j < held_n; j++)
						expected_sorted.push_back('{v: held[j], eor: (j == held_n - 1),
							ovf: dropped});
					held_n = 0;
					dropped = 1'b0;
				end
			end
			pending = expected_sorted.size();
		end
	end

endmodule
`default_nettype wire

[verif/min_heap_sorter_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_sorter_tb
// Testbench top for the min-heap sorter.
// ----------------------------------------------------------------------------
// Sends sets of signed values with bursty input and a stalling receiver:
// a short directed part with extreme values, ties and single-value sets,
// then random sets, including a full store and an overrun past capacity.
// The receiver holds off once for a long stretch so the block backs up.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module min_heap_sorter_tb;
	import mhs_pkg::*;

	localparam int    CAPACITY       = 64;
	localparam int    ITEM_TARGET    = 270;
	localparam int    WATCHDOG_LIMIT = 8000;
	localparam int    HOLD_OFF       = 400;
	localparam data_t DATA_MIN       = {1'b1, {(DATA_W-1){1'b0}}};
	localparam data_t DATA_MAX       = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum int {VAL_FULL, VAL_TIES, VAL_EXTREME} value_mode_t;
	typedef enum int {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	data_t value = '0;
	logic  is_last = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	data_t sorted_value;
	logic  end_of_run;
	logic  overflowed;
	int    fails;
	int    pending;
	int    burst_left = 0;
	int    idle_cycles = 0;
	int    sent = 0;

	min_heap_sorter #(.MAX_ITEMS(CAPACITY)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready), .sorted_value(sorted_value),
		.end_of_run(end_of_run), .overflowed(overflowed)
	);

	min_heap_sorter_chk #(.CAPACITY(CAPACITY)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready), .sorted_value(sorted_value),
		.end_of_run(end_of_run), .overflowed(overflowed),
		.fails(fails), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic data_t pick_value(input value_mode_t m);
		case (m)
			VAL_TIES: return data_t'($urandom_range(0, 9)) - 5;
			VAL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return DATA_MIN;
					1: return DATA_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic offer(input data_t v, input logic l);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		value <= v;
		is_last <= l;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_set(input int n, input value_mode_t m);
		for (int i = 0; i < n; i++)
			offer(pick_value(m), i == n - 1);
	endtask

	// receiver: random stall modes, one long hold-off once results are flowing
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       taken;
		bit       held_off;
		mode = RX_FREE;
		mode_left = 0;
		taken = 0;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			if (!held_off && taken >= 30) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 64);
			end
			mode_left--;
			case (mode)
				RX_FREE: out_ready <= 1'b1;
				RX_HALF: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin : stimulus
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-value sets at both ends of the range
		offer(DATA_MIN, 1'b1);
		offer(DATA_MAX, 1'b1);
		offer(DATA_MAX, 1'b0);
		offer(DATA_MIN, 1'b0);
		offer('0, 1'b0);
		offer(-1, 1'b0);
		offer(1, 1'b1);
		// all equal
		for (int i = 0; i < 4; i++)
			offer(7, i == 3);
		// descending input
		for (int i = 0; i < 8; i++)
			offer(4 - i, i == 7);
		offer(DATA_MIN, 1'b0);
		offer(DATA_MAX, 1'b0);
		offer(DATA_MIN, 1'b1);

		// full store, then an overrun where the closing item is dropped
		send_set(CAPACITY, VAL_FULL);
		send_set(CAPACITY + 3, VAL_TIES);
		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(CAPACITY - 4, CAPACITY + 6);
			else
				n = $urandom_range(1, 12);
			if (n > ITEM_TARGET - sent)
				n = ITEM_TARGET - sent;
			send_set(n, value_mode_t'($urandom_range(0, 2)));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
